FILE: rtl/core/mvt_pkg.sv
// Shared types, constants and helpers for the matrix vertex transform block.
// Used by mvt_front, mvt_back and matrix_vertex_transform. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  // Width of the pre-shifted numerator of the point division.
  localparam int NumW     = DataW + FracBits;
  localparam int DivCntW  = $clog2(NumW);
  // Four floor-shifted products summed without loss.
  localparam int AccW     = 2 * DataW - FracBits + 2;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic signed [DataW-1:0] One    = DataW'(1) << FracBits;
  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [2:0] {
    ACT_LOAD    = 3'd0,
    ACT_XFORM   = 3'd1,
    ACT_POINT   = 3'd2,
    ACT_COMPOSE = 3'd3,
    ACT_IDENT   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO_W = 2'd1,
    ST_SAT    = 2'd2
  } status_e;

  typedef struct packed {
    action_e                  action;
    logic                     bank;
    logic [3:0]               idx;
    logic signed [DataW-1:0]  value;
    logic signed [DataW-1:0]  x;
    logic signed [DataW-1:0]  y;
    logic signed [DataW-1:0]  z;
    logic signed [DataW-1:0]  w;
  } cmd_t;

  function automatic logic signed [DataW-1:0] ident_elem(input logic [3:0] i);
    ident_elem = (i[3:2] == i[1:0]) ? One : '0;
  endfunction

  // Magnitude as an unsigned word; the most negative value maps to 2^31.
  function automatic logic [DataW-1:0] abs_val(input logic signed [DataW-1:0] v);
    abs_val = v[DataW-1] ? DataW'(-v) : DataW'(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mvt_front.sv
// Front end: takes command transactions, drops unused action codes and queues
// the rest for the back end. Depends on mvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mvt_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [2:0]                       action_i,
  input  wire logic                             bank_i,
  input  wire logic [3:0]                       element_index_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] element_value_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] vec_x_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] vec_y_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] vec_z_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] vec_w_i,
  input  wire logic                             pop_i,
  output logic                                  cmd_valid_o,
  output mvt_pkg::cmd_t                         cmd_o
);

  mvt_pkg::cmd_t                   fifo_q [mvt_pkg::QDepth];
  logic [mvt_pkg::QPtrW-1:0]       wr_q, rd_q;
  logic [mvt_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            act_ok, push, pop;
  mvt_pkg::cmd_t                   cmd_in;

  always_comb begin
    case (mvt_pkg::action_e'(action_i))
      mvt_pkg::ACT_LOAD, mvt_pkg::ACT_XFORM, mvt_pkg::ACT_POINT,
      mvt_pkg::ACT_COMPOSE, mvt_pkg::ACT_IDENT: act_ok = 1'b1;
      default: act_ok = 1'b0;
    endcase
  end

  assign busy        = (cnt_q == mvt_pkg::QCntW'(mvt_pkg::QDepth));
  assign push        = start && !busy && act_ok;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && pop_i;
  assign cmd_o       = fifo_q[rd_q];

  assign cmd_in.action = mvt_pkg::action_e'(action_i);
  assign cmd_in.bank   = bank_i;
  assign cmd_in.idx    = element_index_i;
  assign cmd_in.value  = element_value_i;
  assign cmd_in.x      = vec_x_i;
  assign cmd_in.y      = vec_y_i;
  assign cmd_in.z      = vec_z_i;
  assign cmd_in.w      = vec_w_i;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mvt_back.sv
// Back end: matrix banks, shared multiply-accumulate sequencer and bit-serial
// point divider; issues one result per transform. Depends on mvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mvt_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire mvt_pkg::cmd_t               cmd_i,
  output logic                             ready_o,
  output logic                             valid_o,
  output logic signed [mvt_pkg::DataW-1:0] out_x_o,
  output logic signed [mvt_pkg::DataW-1:0] out_y_o,
  output logic signed [mvt_pkg::DataW-1:0] out_z_o,
  output logic signed [mvt_pkg::DataW-1:0] out_w_o,
  output logic [1:0]                       status_o
);

  localparam int DW = mvt_pkg::DataW;
  localparam int NW = mvt_pkg::NumW;
  localparam int AW = mvt_pkg::AccW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAC  = 6'b000010,
    S_WAIT = 6'b000100,
    S_POST = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic signed [DW-1:0]          cur_q [16];
  logic signed [DW-1:0]          opd_q [16];
  logic signed [DW-1:0]          tmp_q [16];
  logic signed [DW-1:0]          res_q [4];
  logic signed [DW-1:0]          vec_q [4];
  logic [5:0]                    cnt_q;
  logic                          is_comp_q, is_point_q;
  logic                          sat_q, zw_q;
  logic signed [2*DW-1:0]        prod_q, prod_d;
  logic                          pv_q, pfirst_q, plast_q;
  logic [3:0]                    ptgt_q;
  logic signed [AW-1:0]          acc_q, acc_sum, shifted;
  logic                          acc_fits;
  logic signed [DW-1:0]          acc_sat;
  logic signed [DW-1:0]          op_a, op_b;
  logic                          last_issue;
  logic [DW-1:0]                 rem_q, rem_n, den_q;
  logic [NW-1:0]                 num_q, num_n;
  logic [DW:0]                   rem_sh;
  logic                          rem_ge, dneg_q;
  logic [mvt_pkg::DivCntW-1:0]   dcnt_q;
  logic [1:0]                    comp_q;
  logic                          div_last, div_sat;
  logic signed [DW-1:0]          div_val;
  logic                          take, start_mac, start_div;
  logic [1:0]                    div_sel;
  logic signed [DW-1:0]          out_x_q, out_y_q, out_z_q, out_w_q;
  mvt_pkg::status_e              out_st_q;
  logic                          valid_q;

  assign ready_o   = (state_q == S_IDLE);
  assign take      = ready_o && cmd_valid_i;
  assign start_mac = take && (cmd_i.action == mvt_pkg::ACT_XFORM ||
                              cmd_i.action == mvt_pkg::ACT_POINT ||
                              cmd_i.action == mvt_pkg::ACT_COMPOSE);

  // Transform: row = n[3:2], column = n[1:0]. Compose: column i = n[5:4],
  // row j = n[3:2], inner k = n[1:0]. The current element index is shared.
  assign op_a       = cur_q[{cnt_q[1:0], cnt_q[3:2]}];
  assign op_b       = is_comp_q ? opd_q[{cnt_q[5:4], cnt_q[1:0]}] : vec_q[cnt_q[1:0]];
  assign prod_d     = op_a * op_b;
  assign last_issue = is_comp_q ? (cnt_q == 6'd63) : (cnt_q[3:0] == 4'd15);

  assign shifted  = AW'(prod_q >>> mvt_pkg::FracBits);
  assign acc_sum  = (pfirst_q ? AW'(0) : acc_q) + shifted;
  assign acc_fits = (&acc_sum[AW-1:DW-1]) || !(|acc_sum[AW-1:DW-1]);
  assign acc_sat  = acc_fits ? acc_sum[DW-1:0]
                  : (acc_sum[AW-1] ? mvt_pkg::SatMin : mvt_pkg::SatMax);

  // Restoring division, one quotient bit per cycle.
  assign rem_sh   = {rem_q, num_q[NW-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_q};
  assign rem_n    = rem_ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
  assign num_n    = {num_q[NW-2:0], rem_ge};
  assign div_last = (dcnt_q == mvt_pkg::DivCntW'(NW - 1));

  always_comb begin
    if (!dneg_q) begin
      div_sat = num_n > NW'(mvt_pkg::SatMax);
      div_val = div_sat ? mvt_pkg::SatMax : num_n[DW-1:0];
    end else begin
      div_sat = num_n > NW'({1'b1, {(DW-1){1'b0}}});
      div_val = div_sat ? mvt_pkg::SatMin : DW'(-num_n[DW-1:0]);
    end
  end

  assign start_div = (state_q == S_POST && is_point_q && !is_comp_q && res_q[3] != '0) ||
                     (state_q == S_DIV && div_last && comp_q != 2'd2);
  assign div_sel   = (state_q == S_POST) ? 2'd0 : comp_q + 2'd1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_mac) state_d = S_MAC;
      S_MAC:  if (last_issue) state_d = S_WAIT;
      S_WAIT: state_d = S_POST;
      S_POST: begin
        if (is_comp_q) begin
          state_d = S_IDLE;
        end else if (start_div) begin
          state_d = S_DIV;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DIV:  if (div_last && comp_q == 2'd2) state_d = S_EMIT;
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pv_q    <= 1'b0;
      valid_q <= 1'b0;
      sat_q   <= 1'b0;
      zw_q    <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        cur_q[i] <= mvt_pkg::ident_elem(4'(i));
        opd_q[i] <= mvt_pkg::ident_elem(4'(i));
      end
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == S_MAC);
      valid_q <= (state_q == S_EMIT);
      if (take) begin
        case (cmd_i.action)
          mvt_pkg::ACT_LOAD: begin
            if (cmd_i.bank) begin
              opd_q[cmd_i.idx] <= cmd_i.value;
            end else begin
              cur_q[cmd_i.idx] <= cmd_i.value;
            end
          end
          mvt_pkg::ACT_IDENT: begin
            for (int i = 0; i < 16; i++) begin
              cur_q[i] <= mvt_pkg::ident_elem(4'(i));
            end
          end
          default: ;
        endcase
        sat_q <= 1'b0;
        zw_q  <= 1'b0;
      end
      if (pv_q && plast_q && !acc_fits && !is_comp_q) begin
        sat_q <= 1'b1;
      end
      if (state_q == S_POST) begin
        if (is_comp_q) begin
          for (int i = 0; i < 16; i++) begin
            cur_q[i] <= tmp_q[i];
          end
        end else if (is_point_q && res_q[3] == '0) begin
          zw_q <= 1'b1;
        end
      end
      if (state_q == S_DIV && div_last && div_sat) begin
        sat_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_mac) begin
      is_comp_q  <= (cmd_i.action == mvt_pkg::ACT_COMPOSE);
      is_point_q <= (cmd_i.action == mvt_pkg::ACT_POINT);
      vec_q[0]   <= cmd_i.x;
      vec_q[1]   <= cmd_i.y;
      vec_q[2]   <= cmd_i.z;
      vec_q[3]   <= (cmd_i.action == mvt_pkg::ACT_POINT) ? mvt_pkg::One : cmd_i.w;
      cnt_q      <= '0;
    end else if (state_q == S_MAC) begin
      cnt_q <= cnt_q + 6'd1;
    end
    prod_q   <= prod_d;
    pfirst_q <= (cnt_q[1:0] == 2'd0);
    plast_q  <= (cnt_q[1:0] == 2'd3);
    ptgt_q   <= is_comp_q ? cnt_q[5:2] : {2'b00, cnt_q[3:2]};
    if (pv_q) begin
      acc_q <= acc_sum;
      if (plast_q) begin
        if (is_comp_q) begin
          tmp_q[ptgt_q] <= acc_sat;
        end else begin
          res_q[ptgt_q[1:0]] <= acc_sat;
        end
      end
    end
    if (state_q == S_POST && is_point_q && !is_comp_q) begin
      den_q <= mvt_pkg::abs_val(res_q[3]);
      if (res_q[3] == '0) begin
        res_q[0] <= '0;
        res_q[1] <= '0;
        res_q[2] <= '0;
      end
    end
    if (state_q == S_DIV && div_last) begin
      res_q[comp_q] <= div_val;
    end
    // A new component restarts the divider; otherwise, in S_DIV, it steps by one bit.
    if (start_div) begin
      comp_q <= div_sel;
      rem_q  <= '0;
      dcnt_q <= '0;
      num_q  <= {mvt_pkg::abs_val(res_q[div_sel]), mvt_pkg::FracBits'(0)};
      dneg_q <= res_q[div_sel][DW-1] ^ res_q[3][DW-1];
    end else if (state_q == S_DIV) begin
      rem_q  <= rem_n;
      num_q  <= num_n;
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (state_q == S_EMIT) begin
      out_x_q  <= res_q[0];
      out_y_q  <= res_q[1];
      out_z_q  <= res_q[2];
      out_w_q  <= zw_q ? '0 : res_q[3];
      out_st_q <= zw_q ? mvt_pkg::ST_ZERO_W : (sat_q ? mvt_pkg::ST_SAT : mvt_pkg::ST_OK);
    end
  end

  assign valid_o  = valid_q;
  assign out_x_o  = out_x_q;
  assign out_y_o  = out_y_q;
  assign out_z_o  = out_z_q;
  assign out_w_o  = out_w_q;
  assign status_o = out_st_q;

endmodule

`default_nettype wire

FILE: rtl/core/matrix_vertex_transform.sv
// Vector transform: 16 products on the shared multiplier, then valid_o rises; a point
// with nonzero w also divides x, y and z by w. Compose runs 64 products into the current
// matrix; load and identity complete as accepted. The back end takes a command only when
// idle; a two-entry command queue takes new transactions while it works; busy is high
// only while the queue is full. Results are a one-cycle strobe on valid_o.
// Reset is asynchronous, active low: both matrices become identity and the queue empties.
`timescale 1ns / 1ps
`default_nettype none

module matrix_vertex_transform (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [2:0]                       action_i,
  input  wire logic                             bank_i,
  input  wire logic [3:0]                       element_index_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] element_value_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] vec_x_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] vec_y_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] vec_z_i,
  input  wire logic signed [mvt_pkg::DataW-1:0] vec_w_i,
  output logic                                  valid_o,
  output logic signed [mvt_pkg::DataW-1:0]      out_x_o,
  output logic signed [mvt_pkg::DataW-1:0]      out_y_o,
  output logic signed [mvt_pkg::DataW-1:0]      out_z_o,
  output logic signed [mvt_pkg::DataW-1:0]      out_w_o,
  output logic [1:0]                            status_o
);

  logic          cmd_valid, back_ready;
  mvt_pkg::cmd_t cmd;

  mvt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .bank_i          (bank_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .vec_x_i         (vec_x_i),
    .vec_y_i         (vec_y_i),
    .vec_z_i         (vec_z_i),
    .vec_w_i         (vec_w_i),
    .pop_i           (back_ready),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  mvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .ready_o     (back_ready),
    .valid_o     (valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

FILE: test/tb_matrix_vertex_transform.sv
// Self-checking testbench for matrix_vertex_transform: loads, composes and transforms
// are driven from a queue and every result strobe is checked against a local predictor.
// Depends on mvt_pkg and the matrix_vertex_transform RTL.
`timescale 1ns / 1ps

module tb_matrix_vertex_transform;
  import mvt_pkg::*;

  localparam int       NumRandom  = 930;
  localparam int       CycleLimit = 1000000;
  localparam int       ResetLen   = 9;
  localparam int       DrainWait  = 200;
  localparam int       WIdx       = 3;
  localparam logic [2:0] ActSpareFirst = 3'd5;
  localparam logic [2:0] ActSpareLast  = 3'd7;

  typedef struct {
    logic signed [DataW-1:0] x, y, z, w;
    status_e                 status;
  } xform_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start;
  logic busy;
  logic [2:0] action_i;
  logic bank_i;
  logic [3:0] element_index_i;
  logic signed [DataW-1:0] element_value_i, vec_x_i, vec_y_i, vec_z_i, vec_w_i;
  logic valid_o;
  logic signed [DataW-1:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic [1:0] status_o;

  matrix_vertex_transform dut (.*);

  always #5 clk_i = ~clk_i;

  cmd_t          pending_cmds[$];
  xform_result_t expected_results[$];
  logic signed [DataW-1:0] cur_mat[16];
  logic signed [DataW-1:0] opnd_mat[16];
  int cycles, accepted, total_items, errors, results_seen, zero_w_seen, sat_seen;
  int idle_pct;

  function automatic logic signed [DataW-1:0] clamp_word(input longint v, inout bit flag);
    if (v > longint'(SatMax)) begin
      flag = 1'b1;
      return SatMax;
    end
    if (v < longint'(SatMin)) begin
      flag = 1'b1;
      return SatMin;
    end
    return v[DataW-1:0];
  endfunction

  // Product rounded toward minus infinity: an arithmetic shift of the exact product.
  function automatic longint scaled_product(input logic signed [DataW-1:0] a,
                                            input logic signed [DataW-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FracBits;
  endfunction

  function automatic logic signed [DataW-1:0] divide_point(
      input logic signed [DataW-1:0] num, input logic signed [DataW-1:0] den,
      inout bit flag);
    longint unsigned n, d, q;
    longint s;
    n = (num < 0) ? longint'(-longint'(num)) : longint'(num);
    d = (den < 0) ? longint'(-longint'(den)) : longint'(den);
    q = (n << FracBits) / d;
    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    s = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    return clamp_word(s, flag);
  endfunction

  task automatic reset_matrices();
    for (int i = 0; i < 16; i++) begin
      cur_mat[i]  = (i / 4 == i % 4) ? One : '0;
      opnd_mat[i] = (i / 4 == i % 4) ? One : '0;
    end
  endtask

  task automatic predict_command(input cmd_t c);
    logic signed [DataW-1:0] v[4];
    logic signed [DataW-1:0] r[4];
    logic signed [DataW-1:0] tmp[16];
    longint acc;
    bit sat;
    xform_result_t res;
    sat = 1'b0;
    case (c.action)
      ACT_LOAD: begin
        if (c.bank) opnd_mat[c.idx] = c.value;
        else cur_mat[c.idx] = c.value;
      end
      ACT_IDENT: begin
        for (int i = 0; i < 16; i++) cur_mat[i] = (i / 4 == i % 4) ? One : '0;
      end
      ACT_COMPOSE: begin
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
              acc += scaled_product(cur_mat[k*4+j], opnd_mat[i*4+k]);
            tmp[i*4+j] = clamp_word(acc, sat);
          end
        cur_mat = tmp;
      end
      ACT_XFORM, ACT_POINT: begin
        v[0] = c.x;
        v[1] = c.y;
        v[2] = c.z;
        v[3] = (c.action == ACT_POINT) ? One : c.w;
        for (int row = 0; row < 4; row++) begin
          acc = 0;
          for (int col = 0; col < 4; col++)
            acc += scaled_product(cur_mat[col*4+row], v[col]);
          r[row] = clamp_word(acc, sat);
        end
        res.status = ST_OK;
        if (c.action == ACT_POINT && r[WIdx] == 0) begin
          r[0] = '0;
          r[1] = '0;
          r[2] = '0;
          res.status = ST_ZERO_W;
        end else begin
          if (c.action == ACT_POINT)
            for (int i = 0; i < 3; i++) r[i] = divide_point(r[i], r[WIdx], sat);
          if (sat) res.status = ST_SAT;
        end
        res.x = r[0];
        res.y = r[1];
        res.z = r[2];
        res.w = r[3];
        expected_results.push_back(res);
      end
      default: ;  // spare action codes leave the state alone
    endcase
  endtask

  task automatic queue_cmd(input logic [2:0] act, input logic bank, input logic [3:0] idx,
                           input logic signed [DataW-1:0] value,
                           input logic signed [DataW-1:0] x, input logic signed [DataW-1:0] y,
                           input logic signed [DataW-1:0] z, input logic signed [DataW-1:0] w);
    cmd_t c;
    c.action = action_e'(act);
    c.bank   = bank;
    c.idx    = idx;
    c.value  = value;
    c.x      = x;
    c.y      = y;
    c.z      = z;
    c.w      = w;
    pending_cmds.push_back(c);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(262143)) - 131072;
      2: begin
        case ($urandom_range(3))
          0: return SatMax;
          1: return SatMin;
          2: return '0;
          default: return One;
        endcase
      end
      default: return $signed($urandom_range(33554431)) - 16777216;
    endcase
  endfunction

  // Driver: holds a transaction on the ports until it is taken, then maybe idles.
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      start           <= 1'b0;
      action_i        <= ACT_LOAD;
      bank_i          <= 1'b0;
      element_index_i <= '0;
      element_value_i <= '0;
      vec_x_i         <= '0;
      vec_y_i         <= '0;
      vec_z_i         <= '0;
      vec_w_i         <= '0;
    end else begin
      if (start && !busy) begin
        c.action = action_e'(action_i);
        c.bank   = bank_i;
        c.idx    = element_index_i;
        c.value  = element_value_i;
        c.x      = vec_x_i;
        c.y      = vec_y_i;
        c.z      = vec_z_i;
        c.w      = vec_w_i;
        predict_command(c);
        accepted++;
      end
      if ((start && !busy) || !start) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          c = pending_cmds.pop_front();
          start           <= 1'b1;
          action_i        <= c.action;
          bank_i          <= c.bank;
          element_index_i <= c.idx;
          element_value_i <= c.value;
          vec_x_i         <= c.x;
          vec_y_i         <= c.y;
          vec_z_i         <= c.z;
          vec_w_i         <= c.w;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Idling phases follow progress through the stimulus.
  always_comb begin
    case ((accepted * 4) / (total_items + 1))
      1: idle_pct = 77;
      3: idle_pct = 10;
      default: idle_pct = 0;
    endcase
  end

  // Monitor: every strobe must match the oldest outstanding expectation.
  always @(posedge clk_i) begin
    xform_result_t e;
    cycles++;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result strobe with no transform outstanding");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status_o == ST_ZERO_W) zero_w_seen++;
        if (status_o == ST_SAT) sat_seen++;
        if (out_x_o !== e.x) begin
          $error("out_x expected %0d actual %0d", e.x, out_x_o);
          errors++;
        end
        if (out_y_o !== e.y) begin
          $error("out_y expected %0d actual %0d", e.y, out_y_o);
          errors++;
        end
        if (out_z_o !== e.z) begin
          $error("out_z expected %0d actual %0d", e.z, out_z_o);
          errors++;
        end
        if (out_w_o !== e.w) begin
          $error("out_w expected %0d actual %0d", e.w, out_w_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    cycles = 0;
    accepted = 0;
    errors = 0;
    results_seen = 0;
    zero_w_seen = 0;
    sat_seen = 0;
    reset_matrices();

    // Identity transforms at the extremes of the vector fields.
    queue_cmd(ACT_XFORM, 1'b0, 4'd0, '0, SatMax, SatMin, '0, -1);
    queue_cmd(ACT_POINT, 1'b1, 4'd15, SatMin, SatMin, SatMax, One, SatMax);
    // Two large elements on row 0 overflow the dot product.
    queue_cmd(ACT_LOAD, 1'b0, 4'd0, SatMax, '0, '0, '0, '0);
    queue_cmd(ACT_LOAD, 1'b0, 4'd4, SatMax, '0, '0, '0, '0);
    queue_cmd(ACT_XFORM, 1'b0, 4'd0, '0, SatMax, SatMax, SatMax, SatMax);
    // A zero bottom row forces a zero w for points.
    for (int i = 3; i < 16; i += 4) queue_cmd(ACT_LOAD, 1'b0, 4'(i), '0, '0, '0, '0, '0);
    queue_cmd(ACT_POINT, 1'b0, 4'd0, '0, 32'sd12345, -32'sd777, SatMax, '0);
    queue_cmd(ACT_IDENT, 1'b0, 4'd0, '0, '0, '0, '0, '0);
    // A tiny w makes the point division overflow.
    queue_cmd(ACT_LOAD, 1'b0, 4'd15, 32'sd1, '0, '0, '0, '0);
    queue_cmd(ACT_POINT, 1'b0, 4'd0, '0, SatMin, 32'sd3, -32'sd3, '0);
    queue_cmd(ACT_LOAD, 1'b1, 4'd5, SatMin, '0, '0, '0, '0);
    queue_cmd(ACT_LOAD, 1'b1, 4'd10, SatMax, '0, '0, '0, '0);
    queue_cmd(ACT_COMPOSE, 1'b0, 4'd0, '0, '0, '0, '0, '0);
    queue_cmd(ACT_XFORM, 1'b0, 4'd0, '0, One, One, One, One);
    for (int a = ActSpareFirst; a <= ActSpareLast; a++)
      queue_cmd(3'(a), 1'b1, 4'd0, SatMax, '0, '0, '0, '0);
    queue_cmd(ACT_IDENT, 1'b0, 4'd0, '0, '0, '0, '0, '0);
    queue_cmd(ACT_POINT, 1'b0, 4'd0, '0, -32'sd65536, 32'sd65536, 32'sd1, '0);

    for (int n = 0; n < NumRandom; n++) begin
      r = $urandom_range(99);
      if (r < 45)
        queue_cmd(ACT_LOAD, 1'($urandom), 4'($urandom), pick_value(), $urandom, $urandom,
                  $urandom, $urandom);
      else if (r < 70)
        queue_cmd(ACT_XFORM, 1'($urandom), 4'($urandom), $urandom, pick_value(),
                  pick_value(), pick_value(), pick_value());
      else if (r < 88) begin
        if ($urandom_range(19) == 0)
          for (int i = 3; i < 16; i += 4) queue_cmd(ACT_LOAD, 1'b0, 4'(i), '0, '0, '0, '0, '0);
        queue_cmd(ACT_POINT, 1'($urandom), 4'($urandom), $urandom, pick_value(),
                  pick_value(), pick_value(), $urandom);
      end else if (r < 93)
        queue_cmd(ACT_COMPOSE, 1'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      else if (r < 97)
        queue_cmd(ACT_IDENT, 1'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      else
        queue_cmd(3'($urandom_range(ActSpareLast, ActSpareFirst)), 1'($urandom),
                  4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    total_items = pending_cmds.size();

    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_cmds.size() == 0 && !start && expected_results.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d transform results never arrived", expected_results.size());
      errors++;
    end

    $display("%0d transactions taken, %0d results checked (%0d zero w, %0d saturated)",
             accepted, results_seen, zero_w_seen, sat_seen);
    $display("%0d mismatches over %0d cycles", errors, cycles);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/mvt_pkg.sv
rtl/core/mvt_front.sv
rtl/core/mvt_back.sv
rtl/core/matrix_vertex_transform.sv
test/tb_matrix_vertex_transform.sv
